/* hdl/bmcd_pkg.sv */
package bmcd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TimerW   = 16;

  localparam logic [CfgIdxW-1:0] CfgClickWindow = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHoldTime    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCooldown    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxClicks   = 3'd3;

  localparam logic [1:0] GestureSingle = 2'd0;
  localparam logic [1:0] GestureDouble = 2'd1;
  localparam logic [1:0] GestureTriple = 2'd2;
  localparam logic [1:0] GestureHold   = 2'd3;

  localparam logic [TimerW-1:0] TimerMax = '1;

  typedef struct packed {
    logic [TimerW-1:0] click_window;
    logic [TimerW-1:0] hold_time;
    logic [TimerW-1:0] cooldown_time;
    logic [1:0]        max_clicks;
  } cfg_t;

  typedef struct packed {
    logic              listening;
    logic [TimerW-1:0] elapsed;
    logic [TimerW-1:0] cooldown;
    logic [1:0]        click_count;
    logic              was_released;
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] gesture;
  } result_t;

endpackage

/* hdl/bmcd_cfg.sv */
module bmcd_cfg
  import bmcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Writes to indexes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.click_window  <= 16'd500;
      cfg_q.hold_time     <= 16'd1000;
      cfg_q.cooldown_time <= 16'd500;
      cfg_q.max_clicks    <= 2'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgClickWindow: cfg_q.click_window  <= cfg_wdata_i;
        CfgHoldTime:    cfg_q.hold_time     <= cfg_wdata_i;
        CfgCooldown:    cfg_q.cooldown_time <= cfg_wdata_i;
        CfgMaxClicks:   cfg_q.max_clicks    <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/bmcd_step.sv */
module bmcd_step
  import bmcd_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  logic    tick_i,
  input  logic    pressed_i,
  output state_t  state_o,
  output result_t result_o
);

  always_comb begin
    state_t s;
    logic   hold;
    s               = state_i;
    hold            = 1'b0;
    result_o.valid   = 1'b0;
    result_o.gesture = GestureSingle;

    if (tick_i) begin
      if (s.listening && (s.elapsed != TimerMax)) begin
        s.elapsed = s.elapsed + 16'd1;
      end
      if (s.cooldown != '0) begin
        s.cooldown = s.cooldown - 16'd1;
      end
    end

    if (s.cooldown == '0) begin
      if (pressed_i) begin
        if (s.listening && (s.elapsed <= cfg_i.click_window)) begin
          if (s.was_released) begin
            s.elapsed = '0;
            if (s.click_count != 2'd3) begin
              s.click_count = s.click_count + 2'd1;
            end
            if (s.click_count >= cfg_i.max_clicks) begin
              s.listening = 1'b0;
              s.cooldown  = cfg_i.cooldown_time;
            end
          end
        end else if (!s.listening && s.was_released) begin
          s.elapsed     = '0;
          s.click_count = 2'd1;
          s.listening   = 1'b1;
        end

        // A long first press turns into a hold and ends the gesture.
        if (s.listening && (s.click_count == 2'd1) && (s.elapsed >= cfg_i.hold_time)) begin
          s.listening      = 1'b0;
          s.click_count    = 2'd0;
          s.cooldown       = cfg_i.cooldown_time;
          hold             = 1'b1;
          result_o.valid   = 1'b1;
          result_o.gesture = GestureHold;
        end
        s.was_released = 1'b0;
      end else begin
        // Release timeout applies whether or not a gesture is open.
        if (s.elapsed >= cfg_i.click_window) begin
          s.elapsed   = '0;
          s.listening = 1'b0;
          s.cooldown  = cfg_i.cooldown_time;
        end
        s.was_released = 1'b1;
      end
    end

    if (!hold && (s.click_count != 2'd0) && !s.listening) begin
      result_o.valid = 1'b1;
      unique case (s.click_count)
        2'd2:    result_o.gesture = GestureDouble;
        2'd3:    result_o.gesture = GestureTriple;
        default: result_o.gesture = GestureSingle;
      endcase
      s.click_count = 2'd0;
    end

    state_o = s;
  end

endmodule

/* hdl/button_multi_click_detector_top.sv */
// Button gesture detector: single, double, triple click or hold.
//
// Input channel (in_valid_i / in_ready_o) carries one button sample per
// request, with a tick flag that marks one elapsed millisecond. Output
// channel (out_valid_o / out_ready_i) carries a gesture code, and only
// for samples that end a gesture; other samples produce no request.
//
// A sample is captured in an input register, then evaluated by the
// gesture step logic, which updates the gesture state and loads the
// output register once that register can take a result. One sample is
// accepted per clock while the output side keeps up.
//
// When the receiver stalls, the held result waits in the output register
// and the sample behind it waits in the input register; in_ready_o drops
// only while both are full. Reset clears both stages, the gesture state
// and loads the default timing registers. Configuration writes take
// effect at once and should be issued only while the block is idle.
module button_multi_click_detector_top
  import bmcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                tick_i,
  input  logic                button_pressed_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          gesture_o
);

  cfg_t    cfg;
  state_t  state_q, state_d;
  result_t step_res;

  logic       in_vld_q;
  logic       tick_q, pressed_q;
  logic       out_vld_q;
  logic [1:0] gesture_q;
  logic       advance;

  bmcd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  bmcd_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .tick_i   (tick_q),
    .pressed_i(pressed_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // The held sample is evaluated once the output register can take a result.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      tick_q    <= tick_i;
      pressed_q <= button_pressed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.listening    <= 1'b0;
      state_q.elapsed      <= '0;
      state_q.cooldown     <= '0;
      state_q.click_count  <= 2'd0;
      state_q.was_released <= 1'b1;
      out_vld_q            <= 1'b0;
    end else if (advance) begin
      state_q   <= state_d;
      out_vld_q <= step_res.valid;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      gesture_q <= step_res.gesture;
    end
  end

  assign out_valid_o = out_vld_q;
  assign gesture_o   = gesture_q;

  // Input side stalls only when both stages are full and the receiver waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

  // An open click count always belongs to an active gesture.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.click_count != 2'd0) |-> state_q.listening)
    else $error("click count left over after gesture end");

  // Gesture state moves only when a sample is evaluated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("gesture state changed without a sample");

  // A result produced by a step is presented on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step_res.valid) |=> out_valid_o)
    else $error("result lost between step and output register");

endmodule
